// File: rtl/core/ithp_pkg.sv
// Package for the IP / transport header parser: phase codes, protocol numbers,
// result codes, the packet summary and result structs. No dependencies.
package ithp_pkg;

   localparam int MAX_EXT_HEADERS_DEF = 8;
   localparam int QUEUE_DEPTH         = 4;
   localparam int EXT_COUNT_W         = 5;
   localparam int RSP_TDATA_W         = 72;

   localparam logic [15:0] V4_MIN_HDR_BYTES = 16'd20;
   localparam logic [15:0] V6_HDR_BYTES     = 16'd40;
   localparam logic [15:0] V6_LAST_HDR_OFF  = 16'd39;
   localparam logic [15:0] EXT_BASE_BYTES   = 16'd8;

   // IP protocol / next header numbers
   localparam logic [7:0] PROTO_HOPOPT = 8'd0;
   localparam logic [7:0] PROTO_ICMP   = 8'd1;
   localparam logic [7:0] PROTO_IGMP   = 8'd2;
   localparam logic [7:0] PROTO_TCP    = 8'd6;
   localparam logic [7:0] PROTO_UDP    = 8'd17;
   localparam logic [7:0] PROTO_ROUTE  = 8'd43;
   localparam logic [7:0] PROTO_FRAG   = 8'd44;
   localparam logic [7:0] PROTO_ICMP6  = 8'd58;
   localparam logic [7:0] PROTO_DSTOPT = 8'd60;

   // transport codes
   localparam logic [2:0] TR_UNKNOWN = 3'd0;
   localparam logic [2:0] TR_TCP     = 3'd1;
   localparam logic [2:0] TR_UDP     = 3'd2;
   localparam logic [2:0] TR_ICMP    = 3'd3;
   localparam logic [2:0] TR_ICMP6   = 3'd4;
   localparam logic [2:0] TR_IGMP    = 3'd5;

   // status codes
   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_IHL_SHORT = 3'd1;
   localparam logic [2:0] ST_TRUNC     = 3'd2;
   localparam logic [2:0] ST_CLAMPED   = 3'd3;
   localparam logic [2:0] ST_UDP_SHORT = 3'd4;
   localparam logic [2:0] ST_MANY_EXT  = 3'd5;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_HDR,
      PH_EXT,
      PH_L4,
      PH_DONE,
      PH_IHL,
      PH_MANY
   } phase_type;

   // per-packet summary handed from front to back
   typedef struct packed {
      phase_type   phase;
      logic        is_six;
      logic [7:0]  next_proto;
      logic [15:0] hdr_bytes;
      logic [15:0] length_field;
      logic [15:0] aux_word;     // UDP length or TCP data offset
      logic [15:0] src_port;
      logic [15:0] dst_port;
   } summary_type;

   typedef struct packed {
      logic        is_six;
      logic [2:0]  transport;
      logic [2:0]  status;
      logic [15:0] src_port;
      logic [15:0] dst_port;
      logic [15:0] payload_len;
      logic [15:0] header_len;
   } result_type;

   function automatic logic is_ext_hdr(input logic [7:0] nh);
      return (nh == PROTO_HOPOPT) || (nh == PROTO_ROUTE) ||
             (nh == PROTO_DSTOPT) || (nh == PROTO_FRAG);
   endfunction

   function automatic logic [2:0] map_transport(input logic [7:0] p);
      logic [2:0] tr;
      case (p)
         PROTO_TCP:   tr = TR_TCP;
         PROTO_UDP:   tr = TR_UDP;
         PROTO_ICMP:  tr = TR_ICMP;
         PROTO_ICMP6: tr = TR_ICMP6;
         PROTO_IGMP:  tr = TR_IGMP;
         default:     tr = TR_UNKNOWN;
      endcase
      return tr;
   endfunction

endpackage

// File: rtl/core/ithp_front.sv
// Front end of the header parser: per-byte walk of IP, extension and L4 headers.
// Emits one packet summary on the last byte. Depends on ithp_pkg.
module ithp_front #(
   parameter int MAX_EXT_HEADERS = ithp_pkg::MAX_EXT_HEADERS_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_take,   // byte transfer this cycle
   input  logic [7:0]          pkt_byte,
   input  logic                first_byte,
   input  logic                last_byte,
   input  logic                family_six,
   output logic                sum_push,
   output ithp_pkg::summary_type sum_data
);
   import ithp_pkg::*;

   phase_type                phase_ff, phase_in;
   logic                     fam_ff, fam_in;
   logic [15:0]              off_ff, off_in;
   logic [15:0]              ihb_ff, ihb_in;
   logic [15:0]              len_ff, len_in;
   logic [7:0]               np_ff, np_in;
   logic [15:0]              eeo_ff, eeo_in;
   logic [EXT_COUNT_W-1:0]   cnt_ff, cnt_in;
   logic [15:0]              sp_ff, sp_in;
   logic [15:0]              dp_ff, dp_in;
   logic [15:0]              aux_ff, aux_in;

   logic [15:0] o;
   logic [16:0] o_inc;
   logic [15:0] rel;
   logic        do_enter;

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         fam_ff   <= 1'b0;
         off_ff   <= '0;
         ihb_ff   <= '0;
         len_ff   <= '0;
         np_ff    <= '0;
         eeo_ff   <= '0;
         cnt_ff   <= '0;
         sp_ff    <= '0;
         dp_ff    <= '0;
         aux_ff   <= '0;
      end else begin
         phase_ff <= phase_in;
         fam_ff   <= fam_in;
         off_ff   <= off_in;
         ihb_ff   <= ihb_in;
         len_ff   <= len_in;
         np_ff    <= np_in;
         eeo_ff   <= eeo_in;
         cnt_ff   <= cnt_in;
         sp_ff    <= sp_in;
         dp_ff    <= dp_in;
         aux_ff   <= aux_in;
      end
   end

   always_comb begin
      phase_in = phase_ff;
      fam_in   = fam_ff;
      off_in   = off_ff;
      ihb_in   = ihb_ff;
      len_in   = len_ff;
      np_in    = np_ff;
      eeo_in   = eeo_ff;
      cnt_in   = cnt_ff;
      sp_in    = sp_ff;
      dp_in    = dp_ff;
      aux_in   = aux_ff;
      o        = '0;
      o_inc    = '0;
      rel      = '0;
      do_enter = 1'b0;
      sum_push = 1'b0;
      sum_data = '0;

      if (byte_take) begin
         // a first byte restarts the walk, dropping any open packet
         if (first_byte) begin
            phase_in = PH_HDR;
            fam_in   = family_six;
            off_in   = '0;
            ihb_in   = '0;
            len_in   = '0;
            np_in    = '0;
            eeo_in   = '0;
            cnt_in   = '0;
            sp_in    = '0;
            dp_in    = '0;
            aux_in   = '0;
         end

         if (phase_in != PH_IDLE) begin
            o     = off_in;
            o_inc = {1'b0, off_in} + 17'd1;
            rel   = (off_in >= ihb_in) ? (off_in - ihb_in) : 16'hFFFF;

            case (phase_in)
               PH_HDR: begin
                  if (!fam_in) begin
                     if (o == 16'd0) begin
                        ihb_in = {10'd0, pkt_byte[3:0], 2'b00};
                        if (ihb_in < V4_MIN_HDR_BYTES) phase_in = PH_IHL;
                     end else if (o == 16'd2) begin
                        len_in[15:8] = pkt_byte;
                     end else if (o == 16'd3) begin
                        len_in[7:0] = pkt_byte;
                     end else if (o == 16'd9) begin
                        np_in = pkt_byte;
                     end
                     if (phase_in == PH_HDR && o_inc == {1'b0, ihb_in}) do_enter = 1'b1;
                  end else begin
                     if (o == 16'd4) begin
                        len_in[15:8] = pkt_byte;
                     end else if (o == 16'd5) begin
                        len_in[7:0] = pkt_byte;
                     end else if (o == 16'd6) begin
                        np_in = pkt_byte;
                     end else if (o == V6_LAST_HDR_OFF) begin
                        ihb_in   = V6_HDR_BYTES;
                        do_enter = 1'b1;
                     end
                  end
               end
               PH_EXT: begin
                  if (rel == 16'd0) begin
                     aux_in = {8'd0, pkt_byte};
                  end else if (rel == 16'd1 && np_in != PROTO_FRAG) begin
                     eeo_in = eeo_in + {5'd0, pkt_byte, 3'b000};
                  end
                  if (o_inc == {1'b0, eeo_in}) begin
                     ihb_in   = eeo_in;
                     np_in    = aux_in[7:0];
                     do_enter = 1'b1;
                  end
               end
               PH_L4: begin
                  if (rel == 16'd0)      sp_in[15:8] = pkt_byte;
                  else if (rel == 16'd1) sp_in[7:0]  = pkt_byte;
                  else if (rel == 16'd2) dp_in[15:8] = pkt_byte;
                  else if (rel == 16'd3) dp_in[7:0]  = pkt_byte;
                  if (np_in == PROTO_TCP) begin
                     if (rel == 16'd12) aux_in = {12'd0, pkt_byte[7:4]};
                     if (rel == 16'd19) phase_in = PH_DONE;
                  end else begin
                     if (rel == 16'd4)      aux_in[15:8] = pkt_byte;
                     else if (rel == 16'd5) aux_in[7:0]  = pkt_byte;
                     if (rel == 16'd7) phase_in = PH_DONE;
                  end
               end
               default: begin
               end
            endcase

            // header finished: pick what follows at ihb_in
            if (do_enter) begin
               if (np_in == PROTO_TCP || np_in == PROTO_UDP) begin
                  aux_in   = '0;
                  phase_in = PH_L4;
               end else if (fam_in && is_ext_hdr(np_in)) begin
                  if (cnt_in >= EXT_COUNT_W'(MAX_EXT_HEADERS)) begin
                     phase_in = PH_MANY;
                  end else begin
                     cnt_in   = cnt_in + 1'b1;
                     eeo_in   = ihb_in + EXT_BASE_BYTES;
                     aux_in   = '0;
                     phase_in = PH_EXT;
                  end
               end else begin
                  phase_in = PH_DONE;
               end
            end

            if (off_in != 16'hFFFF) off_in = off_in + 16'd1;

            if (last_byte) begin
               sum_push              = 1'b1;
               sum_data.phase        = phase_in;
               sum_data.is_six       = fam_in;
               sum_data.next_proto   = np_in;
               sum_data.hdr_bytes    = ihb_in;
               sum_data.length_field = len_in;
               sum_data.aux_word     = aux_in;
               sum_data.src_port     = sp_in;
               sum_data.dst_port     = dp_in;
               phase_in              = PH_IDLE;
            end
         end
      end
   end

endmodule

// File: rtl/core/ithp_queue.sv
// Short summary queue between parser front and result back end.
// Register storage, one write and one read per cycle. Depends on ithp_pkg.
module ithp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ithp_pkg::summary_type wr_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ithp_pkg::summary_type head
);
   import ithp_pkg::*;

   localparam int PtrW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CntW = $clog2(QUEUE_DEPTH + 1);

   summary_type         mem_ff [QUEUE_DEPTH];
   logic [PtrW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]     cnt_ff, cnt_in;

   assign full       = (cnt_ff == CntW'(QUEUE_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop)      cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) mem_ff[wr_ptr_ff] <= wr_data;
   end

endmodule

// File: rtl/core/ithp_back.sv
// Back end of the header parser: turns a packet summary into the result item
// (transport, status, lengths) and holds it in the output register. Uses ithp_pkg.
module ithp_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ithp_pkg::summary_type head,
   output logic                  pop,
   output logic                  out_valid,
   input  logic                  out_ready,
   output ithp_pkg::result_type  out_data
);
   import ithp_pkg::*;

   logic              out_valid_ff, out_valid_in;
   result_type        out_ff, res;
   logic [15:0]       ext_bytes;
   logic [15:0]       sub_ip;
   logic signed [19:0] tcp_diff;
   logic signed [19:0] icmp_diff;
   logic [2:0]        tr;

   assign pop       = head_valid && (!out_valid_ff || out_ready);
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

   always_comb begin
      ext_bytes = (head.is_six && head.hdr_bytes >= V6_HDR_BYTES) ?
                  (head.hdr_bytes - V6_HDR_BYTES) : 16'd0;
      sub_ip    = head.is_six ? ext_bytes : head.hdr_bytes;
      tcp_diff  = $signed({4'd0, head.length_field}) - $signed({4'd0, sub_ip})
                  - $signed({2'd0, head.aux_word, 2'b00});
      icmp_diff = $signed({4'd0, head.length_field}) - $signed({4'd0, ext_bytes})
                  - 20'sd8;
      tr        = map_transport(head.next_proto);

      res            = '0;
      res.is_six     = head.is_six;
      res.header_len = head.hdr_bytes;
      res.transport  = TR_UNKNOWN;
      res.status     = ST_OK;
      case (head.phase)
         PH_IHL:  res.status = ST_IHL_SHORT;
         PH_MANY: res.status = ST_MANY_EXT;
         PH_DONE: begin
            res.transport = tr;
            if (tr == TR_TCP) begin
               res.src_port = head.src_port;
               res.dst_port = head.dst_port;
               if (tcp_diff < 0) res.status = ST_CLAMPED;
               else              res.payload_len = tcp_diff[15:0];
            end else if (tr == TR_UDP) begin
               res.src_port = head.src_port;
               res.dst_port = head.dst_port;
               if (head.aux_word >= 16'd8) res.payload_len = head.aux_word - 16'd8;
               else                        res.status = ST_UDP_SHORT;
            end else if (tr == TR_ICMP6 && head.is_six) begin
               if (icmp_diff < 0) res.status = ST_CLAMPED;
               else               res.payload_len = icmp_diff[15:0];
            end
         end
         default: res.status = ST_TRUNC;
      endcase

      if (pop)            out_valid_in = 1'b1;
      else if (out_ready) out_valid_in = 1'b0;
      else                out_valid_in = out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else       out_valid_ff <= out_valid_in;
   end

   always_ff @(posedge clock) begin
      if (pop) out_ff <= res;
   end

endmodule

// File: rtl/core/ip_transport_header_parser_core.sv
// Top level of the IP / transport header parser.
// Instantiates ithp_front, ithp_queue and ithp_back; uses ithp_pkg.
//
// Packet bytes stream in one per transfer, starting at an IPv4 or IPv6 header
// (first byte flagged in req_tuser[0], family in req_tuser[1], last byte on
// req_tlast). The block takes one byte every cycle while req_tready is high;
// each byte updates a few counters and fields in the front end, which walks
// the IP header, up to MAX_EXT_HEADERS IPv6 extension headers (hop-by-hop,
// routing, destination, fragment) and the first TCP or UDP bytes. On the last
// byte a packet summary goes into a four-entry queue; the back end computes
// transport, status, ports, payload and header length and shows the result
// on rsp_tvalid from its output register. Bytes outside a packet are dropped,
// and a new first byte discards an open packet without a result. req_tready
// falls only while the queue is full, i.e. when four summaries are waiting
// behind a stalled rsp_tready.
module ip_transport_header_parser_core #(
   parameter int MAX_EXT_HEADERS = ithp_pkg::MAX_EXT_HEADERS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,  // pkt_byte
   input  logic                              req_tlast,  // last_byte
   input  logic [1:0]                        req_tuser,  // first_byte, family_six
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // transport[2:0], status[5:3], src_port[21:6], dst_port[37:22],
   // payload_len[53:38], header_len[69:54], zero pad[71:70]
   output logic [ithp_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   output logic                              rsp_tuser   // is_six
);
   import ithp_pkg::*;

   logic        q_full;
   logic        byte_take;
   logic        sum_push;
   summary_type sum_data;
   logic        head_valid;
   summary_type head;
   logic        pop;
   result_type  res;

   assign req_tready = !q_full;
   assign byte_take  = req_tvalid && req_tready;

   ithp_front #(
      .MAX_EXT_HEADERS (MAX_EXT_HEADERS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .byte_take  (byte_take),
      .pkt_byte   (req_tdata),
      .first_byte (req_tuser[0]),
      .last_byte  (req_tlast),
      .family_six (req_tuser[1]),
      .sum_push   (sum_push),
      .sum_data   (sum_data)
   );

   ithp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (sum_push),
      .wr_data    (sum_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   ithp_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head       (head),
      .pop        (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (res)
   );

   assign rsp_tuser = res.is_six;
   assign rsp_tdata = {2'b00, res.header_len, res.payload_len, res.dst_port,
                       res.src_port, res.status, res.transport};

endmodule

// File: bench/ithp_result_checker.sv
// Result checker for the IP / transport header parser: follows the byte stream,
// predicts each packet's result and compares it with the result channel.
// Depends on ithp_pkg for protocol numbers, codes, phases and the result struct.
module ithp_result_checker
   import ithp_pkg::*;
#(
   parameter int MAX_EXT_HEADERS = MAX_EXT_HEADERS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   input  logic [7:0]             req_tdata,
   input  logic                   req_tlast,
   input  logic [1:0]             req_tuser,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   rsp_tuser,
   output int                     mismatch_count,
   output int                     results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   // packet walk state
   phase_type   phase;
   logic        six;
   logic [15:0] offset;
   logic [15:0] hdr_bytes;
   logic [15:0] len_field;
   logic [7:0]  proto;
   logic [15:0] ext_end;
   logic [4:0]  ext_cnt;
   logic [15:0] sport;
   logic [15:0] dport;
   logic [15:0] aux;        // UDP length, TCP data offset or next header code

   result_type  predicted_results[$];
   int          results_seen;

   task automatic report_mismatch(input string what, input logic [15:0] got,
                                  input logic [15:0] want);
      mismatch_count++;
      if (mismatch_count <= 50)
         $display("%0t result %0d: %s got %h expected %h", $realtime, results_seen, what,
                  got, want);
   endtask

   task automatic clear_walk();
      phase     = PH_IDLE;
      six       = 1'b0;
      offset    = '0;
      hdr_bytes = '0;
      len_field = '0;
      proto     = '0;
      ext_end   = '0;
      ext_cnt   = '0;
      sport     = '0;
      dport     = '0;
      aux       = '0;
   endtask

   function automatic logic is_ext_code(input logic [7:0] nh);
      return nh inside {PROTO_HOPOPT, PROTO_ROUTE, PROTO_DSTOPT, PROTO_FRAG};
   endfunction

   function automatic logic [2:0] transport_of(input logic [7:0] p);
      case (p)
         PROTO_TCP:   return TR_TCP;
         PROTO_UDP:   return TR_UDP;
         PROTO_ICMP:  return TR_ICMP;
         PROTO_ICMP6: return TR_ICMP6;
         PROTO_IGMP:  return TR_IGMP;
         default:     return TR_UNKNOWN;
      endcase
   endfunction

   function automatic logic [15:0] clamp_payload(input int d, inout logic [2:0] st);
      if (d < 0) begin
         st = ST_CLAMPED;
         return 16'd0;
      end
      return 16'(d);
   endfunction

   // a header just ended; the next one starts at hdr_bytes
   task automatic enter_next_header();
      if (proto == PROTO_TCP || proto == PROTO_UDP) begin
         aux   = '0;
         phase = PH_L4;
      end else if (six && is_ext_code(proto)) begin
         if (int'(ext_cnt) >= MAX_EXT_HEADERS) begin
            phase = PH_MANY;
         end else begin
            ext_cnt = ext_cnt + 5'd1;
            ext_end = hdr_bytes + EXT_BASE_BYTES;
            aux     = '0;
            phase   = PH_EXT;
         end
      end else begin
         phase = PH_DONE;
      end
   endtask

   task automatic walk_header_byte(input logic [7:0] b, input logic first,
                                   input logic last, input logic fam);
      int          o;
      logic [15:0] rel;
      logic [15:0] ext;
      logic [15:0] sub;
      logic [2:0]  st;
      result_type  r;

      if (first) begin
         clear_walk();
         six   = fam;
         phase = PH_HDR;
      end
      if (phase == PH_IDLE)
         return;

      o   = offset;
      rel = (offset >= hdr_bytes) ? offset - hdr_bytes : 16'hFFFF;

      case (phase)
         PH_HDR: begin
            if (!six) begin
               if (o == 0) begin
                  hdr_bytes = {10'd0, b[3:0], 2'b00};
                  if (hdr_bytes < V4_MIN_HDR_BYTES)
                     phase = PH_IHL;
               end else if (o == 2) begin
                  len_field[15:8] = b;
               end else if (o == 3) begin
                  len_field[7:0] = b;
               end else if (o == 9) begin
                  proto = b;
               end
               if (phase == PH_HDR && o + 1 == hdr_bytes)
                  enter_next_header();
            end else begin
               if (o == 4) begin
                  len_field[15:8] = b;
               end else if (o == 5) begin
                  len_field[7:0] = b;
               end else if (o == 6) begin
                  proto = b;
               end else if (o == V6_LAST_HDR_OFF) begin
                  hdr_bytes = V6_HDR_BYTES;
                  enter_next_header();
               end
            end
         end
         PH_EXT: begin
            // fragment headers have a fixed size, their length byte is ignored
            if (rel == 0)
               aux = {8'd0, b};
            else if (rel == 1 && proto != PROTO_FRAG)
               ext_end = ext_end + {5'd0, b, 3'b000};
            if (o + 1 == ext_end) begin
               hdr_bytes = ext_end;
               proto     = aux[7:0];
               enter_next_header();
            end
         end
         PH_L4: begin
            if (rel == 0)      sport[15:8] = b;
            else if (rel == 1) sport[7:0]  = b;
            else if (rel == 2) dport[15:8] = b;
            else if (rel == 3) dport[7:0]  = b;
            if (proto == PROTO_TCP) begin
               if (rel == 12) aux = {12'd0, b[7:4]};
               if (rel == 19) phase = PH_DONE;
            end else begin
               if (rel == 4)      aux[15:8] = b;
               else if (rel == 5) aux[7:0]  = b;
               if (rel == 7) phase = PH_DONE;
            end
         end
         default: ;
      endcase

      if (offset != 16'hFFFF)
         offset = offset + 16'd1;
      if (!last)
         return;

      r  = '0;
      st = ST_OK;
      case (phase)
         PH_IHL:  st = ST_IHL_SHORT;
         PH_MANY: st = ST_MANY_EXT;
         PH_DONE: begin
            ext = (six && hdr_bytes >= V6_HDR_BYTES) ? hdr_bytes - V6_HDR_BYTES : 16'd0;
            sub = six ? ext : hdr_bytes;
            r.transport = transport_of(proto);
            if (r.transport == TR_TCP) begin
               r.src_port    = sport;
               r.dst_port    = dport;
               r.payload_len = clamp_payload(int'(len_field) - int'(sub) - int'(aux) * 4, st);
            end else if (r.transport == TR_UDP) begin
               r.src_port = sport;
               r.dst_port = dport;
               if (aux >= 16'd8)
                  r.payload_len = aux - 16'd8;
               else
                  st = ST_UDP_SHORT;
            end else if (r.transport == TR_ICMP6 && six) begin
               r.payload_len = clamp_payload(int'(len_field) - int'(ext) - 8, st);
            end
         end
         default: st = ST_TRUNC;
      endcase
      r.is_six     = six;
      r.status     = st;
      r.header_len = hdr_bytes;
      predicted_results.push_back(r);
      phase = PH_IDLE;
   endtask

   task automatic check_result();
      result_type got;
      result_type want;

      got.is_six      = rsp_tuser;
      got.transport   = rsp_tdata[2:0];
      got.status      = rsp_tdata[5:3];
      got.src_port    = rsp_tdata[21:6];
      got.dst_port    = rsp_tdata[37:22];
      got.payload_len = rsp_tdata[53:38];
      got.header_len  = rsp_tdata[69:54];
      results_seen++;
      if (predicted_results.size() == 0) begin
         report_mismatch("unexpected result, header_len", got.header_len, 16'd0);
         return;
      end
      want = predicted_results.pop_front();
      if (got.is_six !== want.is_six)
         report_mismatch("is_six", got.is_six, want.is_six);
      if (got.transport !== want.transport)
         report_mismatch("transport", got.transport, want.transport);
      if (got.status !== want.status)
         report_mismatch("status", got.status, want.status);
      if (got.src_port !== want.src_port)
         report_mismatch("src_port", got.src_port, want.src_port);
      if (got.dst_port !== want.dst_port)
         report_mismatch("dst_port", got.dst_port, want.dst_port);
      if (got.payload_len !== want.payload_len)
         report_mismatch("payload_len", got.payload_len, want.payload_len);
      if (got.header_len !== want.header_len)
         report_mismatch("header_len", got.header_len, want.header_len);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         predicted_results.delete();
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_result();
         if (req_tvalid && req_tready)
            walk_header_byte(req_tdata, req_tuser[0], req_tlast, req_tuser[1]);
      end
      results_owed <= predicted_results.size();
   end

endmodule

// File: bench/ip_transport_header_parser_core_test.sv
// Testbench top for ip_transport_header_parser_core: builds IPv4 / IPv6 packets
// with extension chains and TCP / UDP / ICMP payloads, streams them in, gives the verdict.
// Depends on ithp_pkg, the parser RTL and ithp_result_checker.
module ip_transport_header_parser_core_test;
   import ithp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int EXT_LIMIT    = MAX_EXT_HEADERS_DEF;
   localparam int RANDOM_BYTES = 800;   // bytes of random traffic before the quiet tail
   localparam int MIN_PACKETS  = 60;    // and at least this many random packets

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   // byte stream into the parser
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata  = '0;   // pkt_byte
   logic       req_tlast  = 1'b0; // last_byte
   logic [1:0] req_tuser  = '0;   // first_byte, family_six

   // result stream
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b1;
   // transport, status, src_port, dst_port, payload_len, header_len, zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;  // is_six

   int mismatch_count;
   int results_owed;

   // bytes of the packet under construction, IP header first
   logic [7:0] frame[$];
   int         bytes_sent = 0;
   bit         gaps_on    = 1'b1;  // random idle bursts on both sides
   int         stall_left = 0;

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   ip_transport_header_parser_core #(
      .MAX_EXT_HEADERS(EXT_LIMIT)
   ) i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   ithp_result_checker #(
      .MAX_EXT_HEADERS(EXT_LIMIT)
   ) i_checker (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tlast      (req_tlast),
      .req_tuser      (req_tuser),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .rsp_tuser      (rsp_tuser),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   // Result side back-pressure: random stalls with long ready stretches
   // between them. A stall sets tready low and counts stall_left down to one.
   always @(posedge clock) begin
      if (reset || !gaps_on) begin
         stall_left <= 0;
         rsp_tready <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else if ($urandom_range(0, 15) == 0) begin
         stall_left <= $urandom_range(1, 11);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [7:0] rand_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   // ports lean toward the extremes now and then
   function automatic logic [15:0] rand_port();
      case ($urandom_range(0, 7))
         0:       return 16'h0000;
         1:       return 16'hFFFF;
         default: return 16'($urandom_range(0, 65535));
      endcase
   endfunction

   function automatic void push_word(input logic [15:0] w);
      frame.push_back(w[15:8]);
      frame.push_back(w[7:0]);
   endfunction

   function automatic void push_random(input int n);
      for (int i = 0; i < n; i++)
         frame.push_back(rand_byte());
   endfunction

   // length fields: 0 = consistent with the bytes built, 1 = any value,
   // 2 = small enough to go negative
   function automatic logic [15:0] length_for(input int mode, input int n);
      case (mode)
         0:       return 16'(n);
         1:       return 16'($urandom_range(0, 65535));
         default: return 16'($urandom_range(0, 30));
      endcase
   endfunction

   function automatic logic [7:0] ext_code_at(input int k);
      case (k)
         0:       return PROTO_HOPOPT;
         1:       return PROTO_ROUTE;
         2:       return PROTO_DSTOPT;
         default: return PROTO_FRAG;
      endcase
   endfunction

   // transport header plus some payload; mode as in length_for
   function automatic void add_l4(input logic [7:0] proto, input int mode);
      int          opt;
      int          pay;
      logic [3:0]  doff;
      logic [15:0] ulen;

      if (proto == PROTO_TCP) begin
         opt = $urandom_range(0, 3);
         push_word(rand_port());
         push_word(rand_port());
         push_random(8);
         case (mode)
            0:       doff = 4'(5 + opt);
            1:       doff = 4'($urandom_range(0, 15));
            default: doff = 4'hF;
         endcase
         frame.push_back({doff, 4'($urandom_range(0, 15))});
         push_random(7 + opt * 4);
         push_random($urandom_range(0, 12));
      end else if (proto == PROTO_UDP) begin
         pay = $urandom_range(0, 12);
         case (mode)
            0:       ulen = 16'(8 + pay);
            1:       ulen = 16'($urandom_range(0, 65535));
            default: ulen = 16'($urandom_range(0, 7));
         endcase
         push_word(rand_port());
         push_word(rand_port());
         push_word(ulen);
         push_random(2 + pay);
      end else begin
         push_random($urandom_range(0, 16));
      end
   endfunction

   function automatic void build_v4(input logic [3:0] ihl, input logic [7:0] proto,
                                    input int mode);
      int          hlen;
      logic [15:0] tot;

      frame.delete();
      hlen = (ihl < 5) ? 20 : ihl * 4;
      frame.push_back({4'h4, ihl});
      push_random(1);
      push_word(16'h0000);
      push_random(5);
      frame.push_back(proto);
      push_random(hlen - 10);
      add_l4(proto, mode);
      tot = length_for(mode, frame.size());
      frame[2] = tot[15:8];
      frame[3] = tot[7:0];
   endfunction

   // IPv6 base header, n_ext extension headers, then the transport bytes.
   // in_order walks hop-by-hop, routing, destination, fragment in turn;
   // big gives non-fragment headers the largest length byte.
   function automatic void build_v6(input int n_ext, input logic [7:0] proto, input int mode,
                                    input bit big, input bit in_order);
      logic [7:0]  chain[$];
      logic [7:0]  lenb;
      logic [15:0] pl;
      int          span;

      for (int i = 0; i < n_ext; i++)
         chain.push_back(ext_code_at(in_order ? i % 4 : $urandom_range(0, 3)));
      frame.delete();
      frame.push_back({4'h6, 4'($urandom_range(0, 15))});
      push_random(3);
      push_word(16'h0000);
      frame.push_back((n_ext > 0) ? chain[0] : proto);
      push_random(33);
      for (int i = 0; i < n_ext; i++) begin
         frame.push_back((i + 1 < n_ext) ? chain[i + 1] : proto);
         if (chain[i] == PROTO_FRAG) begin
            lenb = rand_byte();
            span = 8;
         end else begin
            lenb = big ? 8'hFF : 8'($urandom_range(0, 2));
            span = 8 + lenb * 8;
         end
         frame.push_back(lenb);
         push_random(span - 2);
      end
      add_l4(proto, mode);
      pl = length_for(mode, frame.size() - 40);
      frame[4] = pl[15:8];
      frame[5] = pl[7:0];
   endfunction

   // one byte transfer, sometimes after an idle burst
   task automatic drive_byte(input logic [7:0] b, input logic first, input logic lst,
                             input logic fam);
      if (gaps_on && $urandom_range(0, 23) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      req_tlast  <= lst;
      req_tuser  <= {fam, first};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      bytes_sent++;
   endtask

   // first keep bytes of the frame; close marks the final one as last.
   // The family bit only matters on the first byte, elsewhere it is noise.
   task automatic send_frame(input int keep, input bit close, input logic fam);
      for (int i = 0; i < keep; i++)
         drive_byte(frame[i], i == 0, close && i == keep - 1,
                    (i == 0) ? fam : 1'($urandom_range(0, 1)));
   endtask

   task automatic send_whole(input logic fam);
      send_frame(frame.size(), 1'b1, fam);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (results_owed != 0) @(posedge clock);
   endtask

   // mostly well-formed packets with random content; some truncated, some
   // abandoned (dropped by the next first byte), some followed by stray bytes
   task automatic random_packet();
      logic [7:0] proto;
      logic [3:0] ihl;
      logic       fam;
      int         mode;
      int         keep;
      bit         close;
      int         shape;

      case ($urandom_range(0, 9))
         0, 1, 2, 3: proto = PROTO_TCP;
         4, 5, 6:    proto = PROTO_UDP;
         7:          proto = ($urandom_range(0, 1) == 0) ? PROTO_ICMP : PROTO_IGMP;
         8:          proto = PROTO_ICMP6;
         default:    proto = rand_byte();
      endcase
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: mode = 0;
         6, 7:             mode = 1;
         default:          mode = 2;
      endcase
      if ($urandom_range(0, 1) == 0) begin
         case ($urandom_range(0, 19))
            0:       ihl = 4'($urandom_range(0, 4));
            1:       ihl = 4'hF;
            default: ihl = 4'($urandom_range(5, 7));
         endcase
         build_v4(ihl, proto, mode);
         fam = 1'b0;
      end else begin
         build_v6(($urandom_range(0, 19) == 0) ? $urandom_range(EXT_LIMIT - 1, EXT_LIMIT + 2)
                                                : $urandom_range(0, 3),
                  proto, mode, 1'b0, 1'b0);
         fam = 1'b1;
      end
      if ($urandom_range(0, 31) == 0)
         fam = ~fam;

      keep  = frame.size();
      close = 1'b1;
      shape = $urandom_range(0, 19);
      if (shape == 0)
         keep = $urandom_range(1, frame.size());
      else if (shape == 1)
         close = 1'b0;
      send_frame(keep, close, fam);
      if (shape == 2) begin
         repeat ($urandom_range(1, 3))
            drive_byte(rand_byte(), 1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      end
   endtask

   initial begin
      int random_from;
      int random_pkts;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed: each transport, port and length extremes
      build_v4(4'd5, PROTO_TCP, 0);
      frame[20] = 8'hFF; frame[21] = 8'hFF; frame[22] = 8'h00; frame[23] = 8'h00;
      send_whole(1'b0);
      build_v4(4'd15, PROTO_UDP, 0);
      frame[60] = 8'h00; frame[61] = 8'h00; frame[62] = 8'hFF; frame[63] = 8'hFF;
      send_whole(1'b0);
      build_v4(4'd5, PROTO_UDP, 2);               // UDP length below 8
      send_whole(1'b0);
      build_v4(4'd6, PROTO_ICMP, 0);
      send_whole(1'b0);
      build_v4(4'd5, PROTO_IGMP, 0);
      send_whole(1'b0);
      build_v4(4'd5, PROTO_ICMP6, 0);             // ICMPv6 over IPv4: no payload length
      send_whole(1'b0);
      build_v4(4'd5, PROTO_HOPOPT, 0);            // extension codes mean nothing in IPv4
      send_whole(1'b0);
      build_v4(4'd5, 8'hFF, 1);
      send_whole(1'b0);
      build_v4(4'd5, PROTO_TCP, 2);               // negative payload, clamped
      send_whole(1'b0);
      build_v4(4'd5, PROTO_TCP, 0);
      frame[2] = 8'hFF; frame[3] = 8'hFF;
      send_whole(1'b0);
      build_v4(4'd0, PROTO_TCP, 0);               // short IHL
      send_whole(1'b0);
      build_v4(4'd4, PROTO_UDP, 0);
      send_whole(1'b0);

      // --- directed: IPv6 and the extension walk
      build_v6(0, PROTO_UDP, 0, 1'b0, 1'b0);
      send_whole(1'b1);
      build_v6(1, PROTO_ICMP6, 0, 1'b0, 1'b0);
      send_whole(1'b1);
      build_v6(0, PROTO_ICMP6, 0, 1'b0, 1'b0);
      frame[4] = 8'h00; frame[5] = 8'h03;         // ICMPv6 payload length clamp
      send_whole(1'b1);
      build_v6(4, PROTO_TCP, 0, 1'b0, 1'b1);      // all four extension kinds
      send_whole(1'b1);
      build_v6(EXT_LIMIT, PROTO_UDP, 0, 1'b0, 1'b1);
      send_whole(1'b1);
      build_v6(EXT_LIMIT + 1, PROTO_TCP, 0, 1'b0, 1'b0);  // one extension too many
      send_whole(1'b1);
      build_v6(1, 8'd59, 0, 1'b0, 1'b0);          // unknown next header ends the walk
      send_whole(1'b1);
      build_v6(1, PROTO_UDP, 0, 1'b1, 1'b1);      // longest hop-by-hop header
      send_whole(1'b1);

      // --- directed: truncation, stray bytes, restart mid packet
      build_v4(4'd5, PROTO_TCP, 0);
      send_frame(1, 1'b1, 1'b0);                  // first and last on one byte
      build_v4(4'd5, PROTO_TCP, 0);
      send_frame(39, 1'b1, 1'b0);                 // TCP header one byte short
      build_v6(2, PROTO_UDP, 0, 1'b0, 1'b1);
      send_frame(45, 1'b1, 1'b1);                 // ends inside an extension header
      build_v6(0, PROTO_UDP, 0, 1'b0, 1'b0);
      send_frame(30, 1'b1, 1'b1);                 // ends inside the IPv6 header
      drive_byte(8'hFF, 1'b0, 1'b1, 1'b1);        // outside a packet: ignored
      drive_byte(8'h00, 1'b0, 1'b1, 1'b0);
      build_v4(4'd5, PROTO_UDP, 0);
      send_frame(12, 1'b0, 1'b0);                 // dropped by the next first byte
      build_v6(0, PROTO_TCP, 0, 1'b0, 1'b0);
      send_whole(1'b1);

      // hold the sender until every result is back
      wait_drained();

      // --- random traffic
      random_from = bytes_sent;
      random_pkts = 0;
      while (bytes_sent - random_from < RANDOM_BYTES || random_pkts < MIN_PACKETS) begin
         random_packet();
         random_pkts++;
         if ($urandom_range(0, 29) == 0)
            wait_drained();
      end

      // quiet tail: no idling on either side
      gaps_on = 1'b0;
      repeat (15) random_packet();

      wait_drained();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   // watchdog, far beyond the slowest legal run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
